// ===== rtl/core/dfs_pkg.sv =====
// Shared constants and types of the depth-first cycle finder.
package dfs_pkg;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF = 256;
    localparam int FIELD_VW = 6;
    localparam int COUNT_W = 7;
    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;
    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_ADD1  = 11'b00000000010,
        S_ADD2  = 11'b00000000100,
        S_START = 11'b00000001000,
        S_HEAD  = 11'b00000010000,
        S_SCAN  = 11'b00000100000,
        S_POP   = 11'b00001000000,
        S_EDGE  = 11'b00010000000,
        S_EREAD = 11'b00100000000,
        S_ECHK  = 11'b01000000000,
        S_ETAIL = 11'b10000000000
    } t_state;
endpackage

// ===== rtl/core/dfs_edge_if.sv =====
// Edge request channel of the cycle finder.
interface dfs_edge_if import dfs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FIELD_VW-1:0] edge_from;
    logic [FIELD_VW-1:0] edge_to;
    logic                last_edge;
    modport source (output valid, edge_from, edge_to, last_edge, input ready);
    modport sink (input valid, edge_from, edge_to, last_edge, output ready);
endinterface

// ===== rtl/core/dfs_result_if.sv =====
// Result request channel of the cycle finder.
interface dfs_result_if import dfs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FIELD_VW-1:0] cycle_vertex;
    logic                cycle_found;
    logic                edges_dropped;
    logic                last_result;
    modport source (output valid, cycle_vertex, cycle_found, edges_dropped, last_result,
                    input ready);
    modport sink (input valid, cycle_vertex, cycle_found, edges_dropped, last_result,
                  output ready);
endinterface

// ===== rtl/core/dfs_cycle_finder.sv =====
// Depth-first cycle finder over an undirected graph held in adjacency memories.
//
//  channel   dir  handshake      payload
//  i_edge    in   valid/ready    edge_from, edge_to, last_edge
//  o_result  out  valid/ready    cycle_vertex, cycle_found, edges_dropped, last_result
//  apb       in   psel/penable   vertex_count at byte address 0
//
// An edge passes a head read and two list inserts on one memory write port;
// a dropped edge skips the inserts. The search visits each list node in S_SCAN and
// S_EDGE (adding S_HEAD when it descends into a new vertex) and pops through S_POP,
// then replays the cycle path off the stack through S_EREAD and S_ECHK.
// Reset is synchronous; per-vertex flags are flops cleared at once, no sweep.
// Loading a result (not-found report, path vertex, tail) holds while the result register waits to be taken.
module dfs_cycle_finder import dfs_pkg::*; #(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dfs_edge_if.sink            i_edge,
    dfs_result_if.source        o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [0:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    localparam int STORE_DEPTH = 2 * MAX_EDGES;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int PW = (STORE_DEPTH > 2) ? $clog2(STORE_DEPTH) : 1;
    localparam int FW = $clog2(STORE_DEPTH + 1);
    localparam int DW = $clog2(MAX_VERTICES + 1);
    localparam int SW = VW + 1 + PW;   // store entry: nbr, nil, next
    localparam int KW = VW + 1 + PW;   // stack entry: vertex, nil, node

    // configuration register
    logic [COUNT_W-1:0] r_vc;
    assign pready = 1'b1;
    assign prdata = {{(32-COUNT_W){1'b0}}, r_vc};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= VERTEX_COUNT_RESET;
        end else if (psel && penable && pwrite && (paddr == REG_VERTEX_COUNT)) begin
            r_vc <= pwdata[COUNT_W-1:0];
        end
    end

    // memories
    logic [PW-1:0]   head_mem  [MAX_VERTICES];
    logic [SW-1:0]   store_mem [STORE_DEPTH];
    logic [KW-1:0]   stack_mem [MAX_VERTICES];
    logic [VW-1:0]   par_mem   [MAX_VERTICES];

    logic            hw_en, sw_en, kw_en, pw_en;
    logic [VW-1:0]   hw_addr, h_raddr, kw_addr, k_raddr, pw_addr, p_raddr;
    logic [PW-1:0]   hw_data, sw_addr, s_raddr;
    logic [SW-1:0]   sw_data;
    logic [KW-1:0]   kw_data;
    logic [VW-1:0]   pw_data;
    logic [PW-1:0]   r_hq;
    logic            r_hqv;
    logic [SW-1:0]   r_sq;
    logic [KW-1:0]   r_kq;
    logic [VW-1:0]   r_pq;

    logic [MAX_VERTICES-1:0] r_hvalid, r_seen, r_done;

    always_ff @(posedge i_clk) begin
        if (hw_en) head_mem[hw_addr] <= hw_data;
        r_hq <= head_mem[h_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (sw_en) store_mem[sw_addr] <= sw_data;
        r_sq <= store_mem[s_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (kw_en) stack_mem[kw_addr] <= kw_data;
        r_kq <= stack_mem[k_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (pw_en) par_mem[pw_addr] <= pw_data;
        r_pq <= par_mem[p_raddr];
    end
    always_ff @(posedge i_clk) begin
        r_hqv <= r_hvalid[h_raddr];
    end

    // control registers
    t_state            r_state, n_state;
    logic [FW-1:0]     r_fill, n_fill;
    logic [DW-1:0]     r_depth, n_depth;
    logic              r_drop, n_drop;
    logic [VW-1:0]     r_from, n_from, r_to, n_to;
    logic              r_last, n_last;
    logic [VW-1:0]     r_cur_v, n_cur_v, r_pend, n_pend, r_hv, n_hv, r_idx, n_idx;
    logic [PW:0]       r_cur_p, n_cur_p;
    logic              r_match, n_match;
    logic              r_ov;
    logic [VW-1:0]     r_ovtx;
    logic              r_ofound, r_odrop, r_olast;
    logic [MAX_VERTICES-1:0] n_hvalid, n_seen, n_done;

    logic              out_load, out_free, accept, edge_ok, do_clear;
    logic [VW-1:0]     o_v;
    logic              o_found, o_last;
    logic [COUNT_W-1:0] n_eff;
    logic [VW-1:0]     y, sv;
    logic [PW:0]       nxt;

    assign out_free = !r_ov || o_result.ready;
    assign i_edge.ready = (r_state == S_LOAD);
    assign accept = i_edge.valid && i_edge.ready;

    // clamp the vertex count and range-check the edge and the store fill
    always_comb begin
        n_eff = r_vc;
        if (r_vc == '0) n_eff = COUNT_W'(1);
        if (r_vc > COUNT_W'(MAX_VERTICES)) n_eff = COUNT_W'(MAX_VERTICES);
        edge_ok = (COUNT_W'(i_edge.edge_from) < n_eff) && (COUNT_W'(i_edge.edge_to) < n_eff)
                  && ((FW+1)'(r_fill) + (FW+1)'(2) <= (FW+1)'(STORE_DEPTH));
    end

    assign y   = r_sq[SW-1 -: VW];
    assign nxt = r_sq[PW:0];
    assign sv  = r_kq[KW-1 -: VW];

    always_comb begin
        n_state = r_state; n_fill = r_fill; n_depth = r_depth; n_drop = r_drop;
        n_from = r_from; n_to = r_to; n_last = r_last;
        n_cur_v = r_cur_v; n_cur_p = r_cur_p; n_pend = r_pend; n_hv = r_hv;
        n_idx = r_idx; n_match = r_match;
        n_hvalid = r_hvalid; n_seen = r_seen; n_done = r_done;
        hw_en = 1'b0; hw_addr = r_from; hw_data = r_fill[PW-1:0]; h_raddr = r_to;
        sw_en = 1'b0; sw_addr = r_fill[PW-1:0]; sw_data = '0; s_raddr = r_cur_p[PW-1:0];
        kw_en = 1'b0; kw_addr = VW'(r_depth - DW'(1)); kw_data = {r_cur_v, nxt};
        k_raddr = r_idx;
        pw_en = 1'b0; pw_addr = y; pw_data = r_cur_v; p_raddr = r_cur_v;
        out_load = 1'b0; o_v = r_cur_v; o_found = 1'b1; o_last = 1'b0;
        do_clear = 1'b0;
        case (r_state)
            S_LOAD: begin
                h_raddr = VW'(i_edge.edge_from);
                if (accept) begin
                    n_from = VW'(i_edge.edge_from);
                    n_to = VW'(i_edge.edge_to);
                    n_last = i_edge.last_edge;
                    if (edge_ok) begin
                        n_state = S_ADD1;
                    end else begin
                        n_drop = 1'b1;
                        if (i_edge.last_edge) n_state = S_START;
                    end
                end
            end
            // insert edge_to at the front of edge_from's list
            S_ADD1: begin
                sw_en = 1'b1;
                sw_data = {r_to, !r_hqv, r_hq};
                hw_en = 1'b1;
                n_hvalid[r_from] = 1'b1;
                n_fill = r_fill + FW'(1);
                h_raddr = r_to;
                n_state = S_ADD2;
            end
            // insert edge_from at the front of edge_to's list, forward a self loop
            S_ADD2: begin
                sw_en = 1'b1;
                if (r_from == r_to) sw_data = {r_from, 1'b0, PW'(r_fill - FW'(1))};
                else sw_data = {r_from, !r_hqv, r_hq};
                hw_en = 1'b1;
                hw_addr = r_to;
                n_hvalid[r_to] = 1'b1;
                n_fill = r_fill + FW'(1);
                n_state = r_last ? S_START : S_LOAD;
            end
            S_START: begin
                h_raddr = '0;
                n_seen[0] = 1'b1;
                n_pend = '0;
                n_depth = DW'(1);
                n_state = S_HEAD;
            end
            S_HEAD: begin
                n_cur_v = r_pend;
                n_cur_p = {!r_hqv, r_hq};
                n_state = S_SCAN;
            end
            S_SCAN: begin
                k_raddr = VW'(r_depth - DW'(2));
                if (r_cur_p[PW]) begin
                    if (r_depth == DW'(1)) begin
                        // no back edge reachable from vertex 0: report not found
                        if (out_free) begin
                            out_load = 1'b1; o_v = '0; o_found = 1'b0; o_last = 1'b1;
                            do_clear = 1'b1;
                            n_state = S_LOAD;
                        end
                    end else begin
                        n_done[r_cur_v] = 1'b1;
                        n_depth = r_depth - DW'(1);
                        n_state = S_POP;
                    end
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_POP: begin
                n_cur_v = sv;
                n_cur_p = r_kq[PW:0];
                n_state = S_SCAN;
            end
            S_EDGE: begin
                h_raddr = y;
                if (!r_seen[y]) begin
                    // descend into a new vertex
                    n_seen[y] = 1'b1;
                    pw_en = 1'b1;
                    kw_en = 1'b1;
                    n_depth = r_depth + DW'(1);
                    n_pend = y;
                    n_state = S_HEAD;
                end else if (!r_done[y] && !((r_cur_v != '0) && (r_pq == y))) begin
                    // back edge: replay the stack from the ancestor up
                    n_hv = y;
                    n_idx = '0;
                    n_match = 1'b0;
                    n_state = (r_depth == DW'(1)) ? S_ETAIL : S_EREAD;
                end else begin
                    n_cur_p = nxt;
                    n_state = S_SCAN;
                end
            end
            S_EREAD: begin
                n_state = S_ECHK;
            end
            S_ECHK: begin
                if (r_match || (sv == r_hv)) begin
                    if (out_free) begin
                        out_load = 1'b1; o_v = sv;
                        n_match = 1'b1;
                        n_idx = r_idx + VW'(1);
                        n_state = (DW'(r_idx) == r_depth - DW'(2)) ? S_ETAIL : S_EREAD;
                    end
                end else begin
                    n_idx = r_idx + VW'(1);
                    n_state = (DW'(r_idx) == r_depth - DW'(2)) ? S_ETAIL : S_EREAD;
                end
            end
            S_ETAIL: begin
                if (out_free) begin
                    out_load = 1'b1; o_last = 1'b1;
                    do_clear = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
        if (do_clear) begin
            n_hvalid = '0; n_seen = '0; n_done = '0;
            n_fill = '0; n_depth = '0; n_drop = 1'b0;
        end
    end

    // hold state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_fill <= '0;
            r_depth <= '0;
            r_drop <= 1'b0;
            r_hvalid <= '0;
            r_seen <= '0;
            r_done <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill <= n_fill;
            r_depth <= n_depth;
            r_drop <= n_drop;
            r_hvalid <= n_hvalid;
            r_seen <= n_seen;
            r_done <= n_done;
            if (out_load) r_ov <= 1'b1;
            else if (o_result.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_from <= n_from; r_to <= n_to; r_last <= n_last;
        r_cur_v <= n_cur_v; r_cur_p <= n_cur_p; r_pend <= n_pend;
        r_hv <= n_hv; r_idx <= n_idx; r_match <= n_match;
        if (out_load) begin
            r_ovtx <= o_v;
            r_ofound <= o_found;
            r_odrop <= r_drop;
            r_olast <= o_last;
        end
    end

    assign o_result.valid = r_ov;
    assign o_result.cycle_vertex = FIELD_VW'(r_ovtx);
    assign o_result.cycle_found = r_ofound;
    assign o_result.edges_dropped = r_odrop;
    assign o_result.last_result = r_olast;
endmodule
